// File: src/pcwrl_pkg.sv
`timescale 1ns / 1ps

package pcwrl_pkg;

  // Client table geometry
  localparam int CLIENTS  = 256;
  localparam int CLIENT_W = $clog2(CLIENTS);

  // Field widths
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SUBMISSIONS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INVALID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUPLICATES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_LENGTH      = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST   = 16'd60;
  localparam logic [CFG_W-1:0] MAX_SUBMISSIONS_RST = 16'd300;
  localparam logic [CFG_W-1:0] MAX_INVALID_RST     = 16'd80;
  localparam logic [CFG_W-1:0] MAX_DUPLICATES_RST  = 16'd140;
  localparam logic [CFG_W-1:0] BAN_LENGTH_RST      = 16'd120;

  // Outcome codes
  localparam logic [1:0] OUTCOME_ORDINARY  = 2'd0;
  localparam logic [1:0] OUTCOME_INVALID   = 2'd1;
  localparam logic [1:0] OUTCOME_DUPLICATE = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_PASSED  = 2'd0;
  localparam logic [1:0] STATUS_BANNED  = 2'd1;
  localparam logic [1:0] STATUS_FLOOD   = 2'd2;

  typedef struct packed {
    logic [7:0]        client_index;
    logic [TIME_W-1:0] now_seconds;
    logic [1:0]        outcome;
  } sub_t;

  typedef struct packed {
    logic [1:0] status;
    logic       ban_started;
  } res_t;

  // One client entry, apart from its used flag
  typedef struct packed {
    logic [TIME_W-1:0]  window_begin;
    logic [COUNT_W-1:0] submit_count;
    logic [COUNT_W-1:0] invalid_count;
    logic [COUNT_W-1:0] duplicate_count;
    logic [TIME_W-1:0]  ban_end;
  } entry_t;

  // Saturating counter increment
  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// File: src/pcwrl_sub_if.sv
`timescale 1ns / 1ps

interface pcwrl_sub_if;
  import pcwrl_pkg::*;

  logic valid;
  logic ready;
  sub_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/pcwrl_res_if.sv
`timescale 1ns / 1ps

interface pcwrl_res_if;
  import pcwrl_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/per_client_window_rate_limiter.sv
`timescale 1ns / 1ps

// Per-client fixed-window submission rate limiter.
// in_ch carries one submission per transaction (client index, current second,
// outcome class); out_ch returns one result per submission (status and a flag
// for a newly started ban), in order. cfg_we/cfg_index/cfg_data write the five
// limit registers; write them only while no submission is in flight.
// Path: an accepted submission waits in the compute stage; when that stage
// fires, its result is registered in the output register that drives out_ch.
// Throughput: one submission per cycle while out_ch is not stalled, set by
// the single read-modify-write of the client table: the entry is read on
// accept and written back when the stage fires, with a one-deep bypass
// for back-to-back submissions from the same client.
// Reset: the limit registers take their defaults and every client entry reads as
// unused with zero counters and no ban; no clearing pass, so in_ch is ready.
// Stall: the result waits in the output register; one more submission can sit
// in the compute stage behind it, after which in_ch.ready drops until
// out_ch.ready is seen.
module per_client_window_rate_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  pcwrl_sub_if.sink                   in_ch,
  pcwrl_res_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [pcwrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcwrl_pkg::CFG_W-1:0] cfg_data
);
  import pcwrl_pkg::*;

  // Limit registers
  logic [CFG_W-1:0] window_length_r;
  logic [CFG_W-1:0] max_submissions_r;
  logic [CFG_W-1:0] max_invalid_r;
  logic [CFG_W-1:0] max_duplicates_r;
  logic [CFG_W-1:0] ban_length_r;

  // Client table: used flags in flops, the rest in a memory
  logic [CLIENTS-1:0] used_r;
  entry_t             mem_r [CLIENTS];

  // Compute stage
  logic                s1_valid_r;
  sub_t                s1_sub_r;
  logic [CLIENT_W-1:0] s1_idx_r;
  entry_t              rd_entry_r;
  logic                rd_used_r;
  logic                hit_r;
  entry_t              fwd_entry_r;

  // Output register
  logic out_valid_r;
  res_t out_data_r;

  logic                in_accept;
  logic                s1_fire;
  logic [CLIENT_W-1:0] in_idx;
  logic                hit_nxt;

  entry_t            cur;
  logic              cur_used;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] age;
  logic              reopen;
  logic [TIME_W:0]   ban_sum;
  logic [TIME_W-1:0] ban_until;
  entry_t            wr_entry;
  logic [COUNT_W-1:0] inv_inc;
  logic [COUNT_W-1:0] dup_inc;
  res_t              res_nxt;

  // Handshake
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_idx    = in_ch.data.client_index[CLIENT_W-1:0];
  assign hit_nxt   = s1_fire && (s1_idx_r == in_idx);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Write the limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r   <= WINDOW_LENGTH_RST;
      max_submissions_r <= MAX_SUBMISSIONS_RST;
      max_invalid_r     <= MAX_INVALID_RST;
      max_duplicates_r  <= MAX_DUPLICATES_RST;
      ban_length_r      <= BAN_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:   window_length_r   <= cfg_data;
        REG_MAX_SUBMISSIONS: max_submissions_r <= cfg_data;
        REG_MAX_INVALID:     max_invalid_r     <= cfg_data;
        REG_MAX_DUPLICATES:  max_duplicates_r  <= cfg_data;
        REG_BAN_LENGTH:      ban_length_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read the entry on accept, write it back when the stage fires
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_entry_r <= mem_r[in_idx];
    end
    if (s1_fire) begin
      mem_r[s1_idx_r] <= wr_entry;
    end
  end

  // Used flags and stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      rd_used_r   <= 1'b0;
    end else begin
      if (s1_fire) begin
        used_r[s1_idx_r] <= 1'b1;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        hit_r      <= hit_nxt;
        rd_used_r  <= used_r[in_idx];
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload, bypass copy and result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sub_r <= in_ch.data;
      s1_idx_r <= in_idx;
    end
    if (s1_fire) begin
      fwd_entry_r <= wr_entry;
      out_data_r  <= res_nxt;
    end
  end

  // Update one client entry
  always_comb begin
    now      = s1_sub_r.now_seconds;
    cur_used = hit_r || rd_used_r;
    if (hit_r) begin
      cur = fwd_entry_r;
    end else if (rd_used_r) begin
      cur = rd_entry_r;
    end else begin
      cur = '0;
    end

    // Reopen an unused or expired window, keeping the ban end
    age    = now - cur.window_begin;
    reopen = !cur_used || (age >= {{(TIME_W-CFG_W){1'b0}}, window_length_r});
    wr_entry = cur;
    if (reopen) begin
      wr_entry.window_begin    = now;
      wr_entry.submit_count    = '0;
      wr_entry.invalid_count   = '0;
      wr_entry.duplicate_count = '0;
    end

    // Saturating ban end
    ban_sum   = {1'b0, now} + {{(TIME_W+1-CFG_W){1'b0}}, ban_length_r};
    ban_until = ban_sum[TIME_W] ? {TIME_W{1'b1}} : ban_sum[TIME_W-1:0];

    inv_inc = bump(wr_entry.invalid_count);
    dup_inc = bump(wr_entry.duplicate_count);

    res_nxt.status      = STATUS_PASSED;
    res_nxt.ban_started = 1'b0;

    priority if (wr_entry.ban_end > now) begin
      res_nxt.status = STATUS_BANNED;
    end else if (wr_entry.submit_count >= max_submissions_r) begin
      wr_entry.ban_end    = ban_until;
      res_nxt.status      = STATUS_FLOOD;
      res_nxt.ban_started = 1'b1;
    end else begin
      wr_entry.submit_count = bump(wr_entry.submit_count);
      if (s1_sub_r.outcome == OUTCOME_INVALID) begin
        wr_entry.invalid_count = inv_inc;
        if (inv_inc >= max_invalid_r) begin
          wr_entry.ban_end    = ban_until;
          res_nxt.ban_started = 1'b1;
        end
      end else if (s1_sub_r.outcome == OUTCOME_DUPLICATE) begin
        wr_entry.duplicate_count = dup_inc;
        if (dup_inc >= max_duplicates_r) begin
          wr_entry.ban_end    = ban_until;
          res_nxt.ban_started = 1'b1;
        end
      end
    end
  end

endmodule
